>>> rtl/tilt_gesture_detector_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef TILT_GESTURE_DETECTOR_CORE_MACROS_SVH
`define TILT_GESTURE_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define TGD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define TGD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tgd_pkg.sv
package tgd_pkg;

  localparam int WINDOW = 10;

  localparam int SAMPLE_W = 13;
  localparam int LEVEL_W  = 12;
  localparam int GEST_W   = 3;
  localparam int DEV_W    = SAMPLE_W + 1;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);

  // Divide by WINDOW through a rounded-up reciprocal; exact for |sum| < 2**SUM_W.
  localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W     = SUM_W + 1;
  localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [GEST_W-1:0] GEST_NONE  = 3'd0;
  localparam logic [GEST_W-1:0] GEST_UP    = 3'd1;
  localparam logic [GEST_W-1:0] GEST_DOWN  = 3'd2;
  localparam logic [GEST_W-1:0] GEST_LEFT  = 3'd3;
  localparam logic [GEST_W-1:0] GEST_RIGHT = 3'd4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_ZERO     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_ZERO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LEVEL = 2'd3;

  localparam logic [LEVEL_W-1:0] TRIGGER_RESET = 12'd320;
  localparam logic [LEVEL_W-1:0] RELEASE_RESET = 12'd160;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] roll_zero;
    logic signed [SAMPLE_W-1:0] pitch_zero;
    logic [LEVEL_W-1:0]         trigger_level;
    logic [LEVEL_W-1:0]         release_level;
  } cfg_t;

endpackage

>>> rtl/tgd_window.sv
module tgd_window (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  logic signed [tgd_pkg::SAMPLE_W-1:0]   roll_in,
  input  logic signed [tgd_pkg::SAMPLE_W-1:0]   pitch_in,
  output logic signed [tgd_pkg::SUM_W-1:0]      roll_sum,
  output logic signed [tgd_pkg::SUM_W-1:0]      pitch_sum
);

  localparam logic signed [tgd_pkg::SUM_W-1:0] WIN_S = tgd_pkg::SUM_W'(tgd_pkg::WINDOW);
  localparam logic [tgd_pkg::SLOT_W-1:0] LAST_SLOT =
    tgd_pkg::SLOT_W'(tgd_pkg::WINDOW - 1);

  logic signed [tgd_pkg::SAMPLE_W-1:0] roll_win  [tgd_pkg::WINDOW];
  logic signed [tgd_pkg::SAMPLE_W-1:0] pitch_win [tgd_pkg::WINDOW];
  logic [tgd_pkg::SLOT_W-1:0]          slot;
  logic                                primed;

  logic signed [tgd_pkg::SUM_W-1:0] roll_ext, pitch_ext;
  logic signed [tgd_pkg::SUM_W-1:0] roll_old, pitch_old;
  logic signed [tgd_pkg::SUM_W-1:0] roll_sum_next, pitch_sum_next;

  assign roll_ext  = tgd_pkg::SUM_W'(roll_in);
  assign pitch_ext = tgd_pkg::SUM_W'(pitch_in);
  assign roll_old  = tgd_pkg::SUM_W'(roll_win[slot]);
  assign pitch_old = tgd_pkg::SUM_W'(pitch_win[slot]);

  always_comb begin
    if (!primed) begin
      roll_sum_next  = tgd_pkg::SUM_W'(roll_ext * WIN_S);
      pitch_sum_next = tgd_pkg::SUM_W'(pitch_ext * WIN_S);
    end else begin
      roll_sum_next  = roll_sum - roll_old + roll_ext;
      pitch_sum_next = pitch_sum - pitch_old + pitch_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
      slot   <= '0;
    end else if (load) begin
      primed <= 1'b1;
      if (primed) begin
        slot <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      roll_sum  <= roll_sum_next;
      pitch_sum <= pitch_sum_next;
      for (int i = 0; i < tgd_pkg::WINDOW; i++) begin
        if (!primed || slot == tgd_pkg::SLOT_W'(i)) begin
          roll_win[i]  <= roll_in;
          pitch_win[i] <= pitch_in;
        end
      end
    end
  end

endmodule

>>> rtl/tgd_divide.sv
module tgd_divide (
  input  logic                                clk,
  input  logic                                load,
  input  logic signed [tgd_pkg::SUM_W-1:0]    sum,
  output logic signed [tgd_pkg::SAMPLE_W-1:0] avg
);

  logic                           neg;
  logic [tgd_pkg::SUM_W-1:0]      mag;
  logic [tgd_pkg::PROD_W-1:0]     prod;
  logic [tgd_pkg::SAMPLE_W-1:0]   quot;

  // Divide the magnitude, then restore the sign: truncation toward zero.
  assign neg  = sum[tgd_pkg::SUM_W-1];
  assign mag  = neg ? tgd_pkg::SUM_W'(-sum) : tgd_pkg::SUM_W'(sum);
  assign prod = tgd_pkg::PROD_W'(mag) * tgd_pkg::PROD_W'(tgd_pkg::RECIP_MUL);
  assign quot = prod[tgd_pkg::RECIP_SHIFT +: tgd_pkg::SAMPLE_W];

  always_ff @(posedge clk) begin
    if (load) begin
      avg <= neg ? $signed(-quot) : $signed(quot);
    end
  end

endmodule

>>> rtl/tgd_latch.sv
module tgd_latch (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic signed [tgd_pkg::SAMPLE_W-1:0] roll_avg,
  input  logic signed [tgd_pkg::SAMPLE_W-1:0] pitch_avg,
  input  tgd_pkg::cfg_t                       cfg,
  output logic [tgd_pkg::GEST_W-1:0]          gesture
);

  logic signed [tgd_pkg::DEV_W-1:0] dev_roll, dev_pitch;
  logic [tgd_pkg::DEV_W-1:0]        abs_roll, abs_pitch;
  logic [tgd_pkg::DEV_W-1:0]        trig, rel;
  logic [tgd_pkg::GEST_W-1:0]       gesture_next;

  assign dev_roll  = tgd_pkg::DEV_W'(roll_avg) - tgd_pkg::DEV_W'(cfg.roll_zero);
  assign dev_pitch = tgd_pkg::DEV_W'(pitch_avg) - tgd_pkg::DEV_W'(cfg.pitch_zero);
  assign abs_roll  = dev_roll[tgd_pkg::DEV_W-1] ? -dev_roll : dev_roll;
  assign abs_pitch = dev_pitch[tgd_pkg::DEV_W-1] ? -dev_pitch : dev_pitch;
  assign trig      = tgd_pkg::DEV_W'(cfg.trigger_level);
  assign rel       = tgd_pkg::DEV_W'(cfg.release_level);

  always_comb begin
    gesture_next = gesture;
    if (gesture == tgd_pkg::GEST_NONE) begin
      if (abs_pitch > trig || abs_roll > trig) begin
        if (abs_pitch > abs_roll) begin
          gesture_next = (dev_pitch > 0) ? tgd_pkg::GEST_DOWN : tgd_pkg::GEST_UP;
        end else begin
          gesture_next = (dev_roll > 0) ? tgd_pkg::GEST_RIGHT : tgd_pkg::GEST_LEFT;
        end
      end
    end else if (gesture inside {tgd_pkg::GEST_UP, tgd_pkg::GEST_DOWN}) begin
      if (abs_pitch < rel) begin
        gesture_next = tgd_pkg::GEST_NONE;
      end
    end else if (gesture inside {tgd_pkg::GEST_LEFT, tgd_pkg::GEST_RIGHT}) begin
      if (abs_roll < rel) begin
        gesture_next = tgd_pkg::GEST_NONE;
      end
    end else begin
      gesture_next = tgd_pkg::GEST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gesture <= tgd_pkg::GEST_NONE;
    end else if (load) begin
      gesture <= gesture_next;
    end
  end

endmodule

>>> rtl/tilt_gesture_detector_core.sv
// Tilt gesture detector: each transfer carries one roll, pitch and heading sample in
// sixteenths of a degree and yields exactly one result, in order; the result passes
// through the window sums, the divider registers and the output register, and leaves
// when the output is not stalled. Roll and pitch are averaged over the last
// WINDOW samples (the first sample after reset fills the whole window), truncated
// toward zero; the averages minus the configured centers drive a gesture latch with
// hysteresis, and heading passes through. While the output is not stalled, the block
// takes one item per cycle: a running sum per axis is updated in the first stage, the
// second stage divides by WINDOW with one constant multiplier per axis, and the third
// stage updates the latch. Each stage has its own valid bit, so a stalled output only
// holds back the stages behind it once they are full; up to three items can be in
// flight. Write the configuration registers only while no item is in flight.
module tilt_gesture_detector_core (
  input  logic                                    clk,
  input  logic                                    rst,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [tgd_pkg::SAMPLE_W-1:0]     roll_sample,
  input  logic signed [tgd_pkg::SAMPLE_W-1:0]     pitch_sample,
  input  logic [tgd_pkg::SAMPLE_W-1:0]            heading_sample,
  // output channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [tgd_pkg::SAMPLE_W-1:0]     smoothed_roll,
  output logic signed [tgd_pkg::SAMPLE_W-1:0]     smoothed_pitch,
  output logic [tgd_pkg::SAMPLE_W-1:0]            heading_out,
  output logic [tgd_pkg::GEST_W-1:0]              gesture,
  // configuration write port
  input  logic                                    cfg_write,
  input  logic [tgd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [tgd_pkg::SAMPLE_W-1:0]            cfg_data
);

  tgd_pkg::cfg_t cfg;

  // Stage valid bits and the ready chain back from the output register.
  logic s1_valid, s2_valid;
  logic s1_ready, s2_ready, s3_ready;
  logic s1_load, s2_load, s3_load;

  logic signed [tgd_pkg::SUM_W-1:0]    roll_sum, pitch_sum;
  logic signed [tgd_pkg::SAMPLE_W-1:0] roll_avg, pitch_avg;
  logic [tgd_pkg::SAMPLE_W-1:0]        s1_heading, s2_heading;

  assign s3_ready = !out_valid || !out_stall;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  assign s1_load = in_valid && s1_ready;
  assign s2_load = s1_valid && s2_ready;
  assign s3_load = s2_valid && s3_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roll_zero     <= '0;
      cfg.pitch_zero    <= '0;
      cfg.trigger_level <= tgd_pkg::TRIGGER_RESET;
      cfg.release_level <= tgd_pkg::RELEASE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tgd_pkg::CFG_ROLL_ZERO:     cfg.roll_zero     <= $signed(cfg_data);
        tgd_pkg::CFG_PITCH_ZERO:    cfg.pitch_zero    <= $signed(cfg_data);
        tgd_pkg::CFG_TRIGGER_LEVEL: cfg.trigger_level <= cfg_data[tgd_pkg::LEVEL_W-1:0];
        tgd_pkg::CFG_RELEASE_LEVEL: cfg.release_level <= cfg_data[tgd_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  // Heading rides along with the item; smoothed values land in the output register.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_heading <= heading_sample;
    end
    if (s2_load) begin
      s2_heading <= s1_heading;
    end
    if (s3_load) begin
      heading_out    <= s2_heading;
      smoothed_roll  <= roll_avg;
      smoothed_pitch <= pitch_avg;
    end
  end

  // Stage 1: window store and running sums (the sums are the stage payload).
  tgd_window u_window (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_load),
    .roll_in   (roll_sample),
    .pitch_in  (pitch_sample),
    .roll_sum  (roll_sum),
    .pitch_sum (pitch_sum)
  );

  // Stage 2: divide each sum by WINDOW.
  tgd_divide u_div_roll (
    .clk  (clk),
    .load (s2_load),
    .sum  (roll_sum),
    .avg  (roll_avg)
  );

  tgd_divide u_div_pitch (
    .clk  (clk),
    .load (s2_load),
    .sum  (pitch_sum),
    .avg  (pitch_avg)
  );

  // Stage 3: gesture latch; its state register is the gesture output.
  tgd_latch u_latch (
    .clk       (clk),
    .rst       (rst),
    .load      (s3_load),
    .roll_avg  (roll_avg),
    .pitch_avg (pitch_avg),
    .cfg       (cfg),
    .gesture   (gesture)
  );

endmodule

>>> rtl/tgd_checker.sv
`include "tilt_gesture_detector_core_macros.svh"

module tgd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [tgd_pkg::SAMPLE_W-1:0]   smoothed_roll,
  input logic [tgd_pkg::SAMPLE_W-1:0]   smoothed_pitch,
  input logic [tgd_pkg::SAMPLE_W-1:0]   heading_out,
  input logic [tgd_pkg::GEST_W-1:0]     gesture
);

  logic                         in_xfer, out_xfer;
  logic [2:0]                   in_flight;
  logic [tgd_pkg::GEST_W-1:0]   last_gesture;
  logic                         last_vert, last_horiz;

  assign in_xfer    = in_valid && !in_stall;
  assign out_xfer   = out_valid && !out_stall;
  assign last_vert  = (last_gesture == tgd_pkg::GEST_UP) ||
                      (last_gesture == tgd_pkg::GEST_DOWN);
  assign last_horiz = (last_gesture == tgd_pkg::GEST_LEFT) ||
                      (last_gesture == tgd_pkg::GEST_RIGHT);

  // Track items taken but not yet delivered, and the last delivered gesture.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight    <= '0;
      last_gesture <= tgd_pkg::GEST_NONE;
    end else begin
      in_flight <= in_flight + 3'(in_xfer) - 3'(out_xfer);
      if (out_xfer) begin
        last_gesture <= gesture;
      end
    end
  end

  `TGD_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(smoothed_roll) && $stable(smoothed_pitch) &&
    $stable(heading_out) && $stable(gesture), "stalled result changed")

  `TGD_ASSERT_NOW(a_no_phantom, out_valid, in_flight != 3'd0,
    "result shown with no item in flight")

  `TGD_ASSERT_NOW(a_depth, 1'b1, in_flight <= 3'd3, "more than three items in flight")

  `TGD_ASSERT_NOW(a_vert_release, out_valid && last_vert,
    gesture == last_gesture || gesture == tgd_pkg::GEST_NONE,
    "vertical gesture changed without release")

  `TGD_ASSERT_NOW(a_horiz_release, out_valid && last_horiz,
    gesture == last_gesture || gesture == tgd_pkg::GEST_NONE,
    "horizontal gesture changed without release")

endmodule

bind tilt_gesture_detector_core tgd_checker u_tgd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .smoothed_roll  (smoothed_roll),
  .smoothed_pitch (smoothed_pitch),
  .heading_out    (heading_out),
  .gesture        (gesture)
);
